// File: src/clut_pixel_decoder_top_macros.svh
// assertion macros for the palette pixel decoder
`ifndef CLUT_PIXEL_DECODER_TOP_MACROS_SVH
`define CLUT_PIXEL_DECODER_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define CLUTD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define CLUTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/clutd_pkg.sv
// shared types and constants for the palette pixel decoder
package clutd_pkg;

   localparam int INDEX_W = 8;
   localparam int COLOR_W = 16;
   localparam int ARGB_W  = 32;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;

   localparam int SEMI_BIT = 15;
   localparam logic [31:0] ARGB_OPAQUE_BLACK = 32'hFF00_0000;
   localparam logic [31:0] ARGB_CLEAR        = 32'h0000_0000;

   // floor(x / 3) == (x * 683) >> 11 for x below 2048
   localparam logic [9:0] DIV3_MUL   = 10'd683;
   localparam int         DIV3_SHIFT = 11;

   // floor(c * 255 / 31) for each 5-bit channel value
   localparam logic [7:0] EXPAND5_TABLE [32] = '{
      8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
      8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
      8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
      8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
   };

   typedef enum logic {
      ACT_WRITE = 1'b0,
      ACT_PIXEL = 1'b1
   } action_type;

   typedef enum logic {
      MODE_8BIT = 1'b0,
      MODE_4BIT = 1'b1
   } pixel_mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PIXEL_MODE  = 1'b0,
      CSR_FORCE_BLACK = 1'b1
   } csr_index_type;

endpackage

// File: src/clutd_ifs.sv
// valid/ready channel interfaces for pixel requests and pixel results
interface clutd_req_if;
   import clutd_pkg::*;

   logic               valid;
   logic               ready;
   logic               action;
   logic [INDEX_W-1:0] entry_index;
   logic [COLOR_W-1:0] entry_color;
   logic [INDEX_W-1:0] pixel_byte;
   logic               last_byte;

   modport source (
      output valid, action, entry_index, entry_color, pixel_byte, last_byte,
      input  ready
   );
   modport sink (
      input  valid, action, entry_index, entry_color, pixel_byte, last_byte,
      output ready
   );
endinterface

interface clutd_rsp_if;
   import clutd_pkg::*;

   logic              valid;
   logic              ready;
   logic [ARGB_W-1:0] argb;
   logic              last_of_item;
   logic              last_of_image;

   modport source (
      output valid, argb, last_of_item, last_of_image,
      input  ready
   );
   modport sink (
      input  valid, argb, last_of_item, last_of_image,
      output ready
   );
endinterface

// File: src/clutd_palette_ram.sv
// palette memory: one write port, two registered read ports
module clutd_palette_ram #(
   parameter  int DEPTH  = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [clutd_pkg::COLOR_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr0,
   input  logic [ADDR_W-1:0]           rd_addr1,
   output logic [clutd_pkg::COLOR_W-1:0] rd_data0,
   output logic [clutd_pkg::COLOR_W-1:0] rd_data1
);
   import clutd_pkg::*;

   logic [COLOR_W-1:0] mem [DEPTH];
   logic [COLOR_W-1:0] rd_data0_ff;
   logic [COLOR_W-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data0_ff <= mem[rd_addr0];
         rd_data1_ff <= mem[rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

// File: src/clutd_color_conv.sv
// bgr555 plus semitransparency bit to argb8888 conversion
module clutd_color_conv (
   input  logic [clutd_pkg::COLOR_W-1:0] color,
   input  logic                          force_black,
   output logic [clutd_pkg::ARGB_W-1:0]  argb
);
   import clutd_pkg::*;

   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic [9:0]  chan_sum;
   logic [19:0] sum_scaled;
   logic [7:0]  alpha;
   logic        is_black;
   logic        semi;

   always_comb begin
      red        = EXPAND5_TABLE[color[4:0]];
      green      = EXPAND5_TABLE[color[9:5]];
      blue       = EXPAND5_TABLE[color[14:10]];
      semi       = color[SEMI_BIT];
      is_black   = (color[14:0] == 15'd0);
      chan_sum   = 10'(red) + 10'(green) + 10'(blue);
      sum_scaled = 20'(chan_sum) * 20'(DIV3_MUL);
      alpha      = semi ? sum_scaled[DIV3_SHIFT +: 8] : 8'hFF;
      if (is_black) begin
         argb = (semi || force_black) ? ARGB_CLEAR : ARGB_OPAQUE_BLACK;
      end else begin
         argb = {alpha, red, green, blue};
      end
   end

endmodule

// File: src/clut_pixel_decoder_top.sv
// palette pixel decoder: index bytes in, argb8888 pixels out
//
// req_bus carries write transactions (action 0), which store entry_color at
// entry_index in the palette and give no result, and pixel transactions
// (action 1), which carry one index byte. In 8-bit mode a byte gives one
// pixel; in 4-bit mode it gives two, low nibble first. rsp_bus carries one
// pixel per transaction with last_of_item and last_of_image flags.
// csr_wr_en/csr_index/csr_wr_data write pixel_mode and the black
// transparency flag; write them only while the block is idle.
// an accepted pixel passes the palette read register, then the result
// register, on its way to rsp_bus. throughput: one byte per cycle in
// 8-bit mode while rsp_bus.ready stays high; in 4-bit mode the rate is
// lower, set by the single result port draining the pixel pair.
// a palette entry written by one transaction is seen by the next one.
// reset clears the pipeline valids and both csr registers; palette contents
// stay undefined until written. when rsp_bus.ready is low the result holds
// and an empty read stage takes one more byte before req_bus.ready drops.
`include "clut_pixel_decoder_top_macros.svh"

module clut_pixel_decoder_top #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   clutd_req_if.sink                         req_bus,
   clutd_rsp_if.source                       rsp_bus,
   input  logic                              csr_wr_en,
   input  logic [clutd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [clutd_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import clutd_pkg::*;

   localparam int ADDR_W = $clog2(PALETTE_DEPTH);
   localparam logic [11:0] DEPTH_12 = 12'(PALETTE_DEPTH);

   typedef struct packed {
      logic pair;
      logic last;
   } stage_ctl_type;

   // index reduced modulo the palette depth, for raw indices below 16 * depth
   function automatic logic [ADDR_W-1:0] wrap_index(input logic [INDEX_W-1:0] raw);
      logic [11:0] rem;
      rem = 12'(raw);
      for (int k = 3; k >= 0; k--) begin
         if (rem >= (DEPTH_12 << k)) begin
            rem = rem - (DEPTH_12 << k);
         end
      end
      return rem[ADDR_W-1:0];
   endfunction

   pixel_mode_type pixel_mode_ff;
   logic           force_black_ff;

   logic          a_valid_ff, a_valid_in;
   stage_ctl_type a_ctl_ff;

   logic          b_valid_ff, b_valid_in;
   logic          b_second_ff, b_second_in;
   stage_ctl_type b_ctl_ff;
   logic [ARGB_W-1:0] b_argb0_ff;
   logic [ARGB_W-1:0] b_argb1_ff;

   logic              b_free;
   logic              a_to_b;
   logic              req_fire;
   logic              wr_fire;
   logic              pix_fire;
   logic              rsp_fire;
   logic              rsp_final;
   logic [ADDR_W-1:0] rd_addr0;
   logic [ADDR_W-1:0] rd_addr1;
   logic [COLOR_W-1:0] rd_data0;
   logic [COLOR_W-1:0] rd_data1;
   logic [ARGB_W-1:0]  conv_argb0;
   logic [ARGB_W-1:0]  conv_argb1;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_mode_ff  <= MODE_8BIT;
         force_black_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_PIXEL_MODE:  pixel_mode_ff  <= pixel_mode_type'(csr_wr_data[0]);
            CSR_FORCE_BLACK: force_black_ff <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // handshake
   always_comb begin
      rsp_final = !b_ctl_ff.pair || b_second_ff;
      rsp_fire  = rsp_bus.valid && rsp_bus.ready;
      b_free    = !b_valid_ff || (rsp_bus.ready && rsp_final);
      a_to_b    = a_valid_ff && b_free;
      req_bus.ready = !a_valid_ff || b_free;
      req_fire  = req_bus.valid && req_bus.ready;
      wr_fire   = req_fire && (action_type'(req_bus.action) == ACT_WRITE);
      pix_fire  = req_fire && (action_type'(req_bus.action) == ACT_PIXEL);
   end

   // palette read addresses
   always_comb begin
      if (pixel_mode_ff == MODE_4BIT) begin
         rd_addr0 = ADDR_W'(req_bus.pixel_byte[3:0]);
         rd_addr1 = ADDR_W'(req_bus.pixel_byte[7:4]);
      end else begin
         rd_addr0 = wrap_index(req_bus.pixel_byte);
         rd_addr1 = rd_addr0;
      end
   end

   clutd_palette_ram #(
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock    (clock),
      .wr_en    (wr_fire),
      .wr_addr  (wrap_index(req_bus.entry_index)),
      .wr_data  (req_bus.entry_color),
      .rd_en    (pix_fire),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   // read stage
   always_comb begin
      if (pix_fire) begin
         a_valid_in = 1'b1;
      end else if (b_free) begin
         a_valid_in = 1'b0;
      end else begin
         a_valid_in = a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_fire) begin
         a_ctl_ff.pair <= (pixel_mode_ff == MODE_4BIT);
         a_ctl_ff.last <= req_bus.last_byte;
      end
   end

   clutd_color_conv u_conv0 (
      .color       (rd_data0),
      .force_black (force_black_ff),
      .argb        (conv_argb0)
   );

   clutd_color_conv u_conv1 (
      .color       (rd_data1),
      .force_black (force_black_ff),
      .argb        (conv_argb1)
   );

   // result stage
   always_comb begin
      b_valid_in  = b_valid_ff;
      b_second_in = b_second_ff;
      if (b_free) begin
         b_valid_in  = a_valid_ff;
         b_second_in = 1'b0;
      end else if (rsp_fire) begin
         b_second_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff  <= 1'b0;
         b_second_ff <= 1'b0;
      end else begin
         b_valid_ff  <= b_valid_in;
         b_second_ff <= b_second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_to_b) begin
         b_ctl_ff   <= a_ctl_ff;
         b_argb0_ff <= conv_argb0;
         b_argb1_ff <= conv_argb1;
      end
   end

   always_comb begin
      rsp_bus.valid         = b_valid_ff;
      rsp_bus.argb          = b_second_ff ? b_argb1_ff : b_argb0_ff;
      rsp_bus.last_of_item  = rsp_final;
      rsp_bus.last_of_image = rsp_final && b_ctl_ff.last;
   end

   `CLUTD_ASSERT_NOW(a_empty_ready, clock, reset, !a_valid_ff, req_bus.ready,
      "read stage empty but request not ready")
   `CLUTD_ASSERT_NEXT(pix_loads_a, clock, reset, pix_fire, a_valid_ff,
      "accepted pixel transaction not held in read stage")
   `CLUTD_ASSERT_NOW(second_needs_pair, clock, reset, b_second_ff,
      b_valid_ff && b_ctl_ff.pair, "second pixel shown without a pixel pair")
   `CLUTD_ASSERT_NEXT(first_then_second, clock, reset, rsp_fire && !rsp_final,
      rsp_bus.valid && b_second_ff, "second pixel of pair lost")
   `CLUTD_ASSERT_NEXT(a_holds_on_stall, clock, reset, a_valid_ff && !b_free,
      a_valid_ff, "read stage dropped while result stage busy")

endmodule

// File: test/clut_pixel_decoder_top_tb.sv
// self-checking testbench for the palette pixel decoder: directed table, then random traffic
module clut_pixel_decoder_top_tb;
   import clutd_pkg::*;

   localparam int PALETTE_DEPTH = 256;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PHASE_COUNT   = 6;
   localparam int PHASE_ITEMS   = 110;
   localparam int ROW_COUNT     = 25;

   typedef struct packed {
      logic [ARGB_W-1:0] argb;
      logic              last_of_item;
      logic              last_of_image;
   } pixel_type;

   typedef struct {
      pixel_mode_type     mode;
      logic               black_clear;
      action_type         action;
      logic [INDEX_W-1:0] entry_index;
      logic [COLOR_W-1:0] entry_color;
      logic [INDEX_W-1:0] pixel_byte;
      logic               last_byte;
      logic               typed;
      logic [ARGB_W-1:0]  argb_lo;
      logic [ARGB_W-1:0]  argb_hi;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wr_data;

   clutd_req_if req_bus ();
   clutd_rsp_if rsp_bus ();

   clut_pixel_decoder_top #(
      .PALETTE_DEPTH(PALETTE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   // shadow state of the block
   logic [COLOR_W-1:0] palette_shadow [PALETTE_DEPTH];
   pixel_mode_type     mode_shadow;
   logic               black_clear_shadow;
   bit                 entry_loaded [PALETTE_DEPTH];

   pixel_type expected_pixels [$];
   int        mismatch_count = 0;
   int        cycle_count;

   // typed expectation for the transaction being driven
   logic              typed_pending;
   logic [ARGB_W-1:0] typed_lo;
   logic [ARGB_W-1:0] typed_hi;

   stim_row_type directed_rows [ROW_COUNT];

   always #4 clock = ~clock;

   function automatic int widen5(input logic [4:0] c);
      return int'(c) * 255 / 31;
   endfunction

   function automatic logic [ARGB_W-1:0] decode_color(input logic [COLOR_W-1:0] color,
                                                      input logic black_clear);
      int r8, g8, b8, a8;
      if (color[14:0] == 15'd0) begin
         return (color[SEMI_BIT] || black_clear) ? 32'h0000_0000 : 32'hFF00_0000;
      end
      r8 = widen5(color[4:0]);
      g8 = widen5(color[9:5]);
      b8 = widen5(color[14:10]);
      a8 = color[SEMI_BIT] ? (r8 + g8 + b8) / 3 : 255;
      return {a8[7:0], r8[7:0], g8[7:0], b8[7:0]};
   endfunction

   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [COLOR_W-1:0] pick_color();
      logic [COLOR_W-1:0] c;
      case ($urandom_range(0, 9))
         0: c = 16'h0000;
         1: c = 16'h8000;
         2: c = 16'h7FFF;
         3: c = 16'hFFFF;
         4: c = (16'h001F << (5 * $urandom_range(0, 2))) | (16'($urandom_range(0, 1)) << 15);
         default: c = 16'($urandom);
      endcase
      return c;
   endfunction

   task automatic report_mismatch(input string what, input logic [ARGB_W-1:0] got,
                                  input logic [ARGB_W-1:0] want);
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic predict_transaction();
      logic [ARGB_W-1:0] lo;
      logic [ARGB_W-1:0] hi;
      if (req_bus.action == ACT_WRITE) begin
         palette_shadow[8'(req_bus.entry_index % PALETTE_DEPTH)] = req_bus.entry_color;
      end else if (mode_shadow == MODE_8BIT) begin
         lo = typed_pending ? typed_lo
            : decode_color(palette_shadow[8'(req_bus.pixel_byte % PALETTE_DEPTH)],
                           black_clear_shadow);
         expected_pixels.push_back('{argb: lo, last_of_item: 1'b1,
                                     last_of_image: req_bus.last_byte});
      end else begin
         lo = typed_pending ? typed_lo
            : decode_color(palette_shadow[8'(req_bus.pixel_byte[3:0])], black_clear_shadow);
         hi = typed_pending ? typed_hi
            : decode_color(palette_shadow[8'(req_bus.pixel_byte[7:4])], black_clear_shadow);
         expected_pixels.push_back('{argb: lo, last_of_item: 1'b0, last_of_image: 1'b0});
         expected_pixels.push_back('{argb: hi, last_of_item: 1'b1,
                                     last_of_image: req_bus.last_byte});
      end
   endtask

   pixel_type want_pixel;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("pixel with nothing expected", rsp_bus.argb, 32'h0);
            end else begin
               want_pixel = expected_pixels.pop_front();
               if (rsp_bus.argb !== want_pixel.argb)
                  report_mismatch("argb", rsp_bus.argb, want_pixel.argb);
               if (rsp_bus.last_of_item !== want_pixel.last_of_item)
                  report_mismatch("last_of_item", 32'(rsp_bus.last_of_item),
                                  32'(want_pixel.last_of_item));
               if (rsp_bus.last_of_image !== want_pixel.last_of_image)
                  report_mismatch("last_of_image", 32'(rsp_bus.last_of_image),
                                  32'(want_pixel.last_of_image));
            end
         end
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1) predict_transaction();
      end
   end

   task automatic send_txn(input action_type act, input logic [INDEX_W-1:0] idx,
                           input logic [COLOR_W-1:0] color, input logic [INDEX_W-1:0] pbyte,
                           input logic lastb, input int gap, input logic typed,
                           input logic [ARGB_W-1:0] lo, input logic [ARGB_W-1:0] hi);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.action      <= act;
      req_bus.entry_index <= idx;
      req_bus.entry_color <= color;
      req_bus.pixel_byte  <= pbyte;
      req_bus.last_byte   <= lastb;
      typed_pending = typed;
      typed_lo = lo;
      typed_hi = hi;
      if (act == ACT_WRITE) entry_loaded[8'(idx % PALETTE_DEPTH)] = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      @(negedge clock);
   endtask

   task automatic send_palette_write(input logic [INDEX_W-1:0] idx, input int gap);
      send_txn(ACT_WRITE, idx, pick_color(), 8'($urandom), 1'($urandom), gap, 1'b0, '0, '0);
   endtask

   task automatic send_random_item(input bit calm);
      logic [INDEX_W-1:0] pbyte;
      logic [INDEX_W-1:0] lo_idx;
      logic [INDEX_W-1:0] hi_idx;
      if ($urandom_range(0, 99) < 25) begin
         send_palette_write(8'($urandom), calm ? 0 : idle_gap());
      end else begin
         pbyte = 8'($urandom);
         if (mode_shadow == MODE_4BIT) begin
            lo_idx = {4'd0, pbyte[3:0]};
            hi_idx = {4'd0, pbyte[7:4]};
         end else begin
            lo_idx = pbyte;
            hi_idx = pbyte;
         end
         // palette entries must be loaded before they are read
         if (!entry_loaded[lo_idx]) send_palette_write(lo_idx, calm ? 0 : idle_gap());
         if (!entry_loaded[hi_idx]) send_palette_write(hi_idx, calm ? 0 : idle_gap());
         send_txn(ACT_PIXEL, 8'($urandom), 16'($urandom), pbyte, $urandom_range(0, 7) == 0,
                  calm ? 0 : idle_gap(), 1'b0, '0, '0);
      end
   endtask

   task automatic drain(input int settle);
      req_bus.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_settings(input pixel_mode_type mode, input logic black_clear);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_PIXEL_MODE;
      csr_wr_data <= mode;
      @(negedge clock);
      csr_index   <= CSR_FORCE_BLACK;
      csr_wr_data <= black_clear;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      mode_shadow = mode;
      black_clear_shadow = black_clear;
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   initial begin
      int gap;
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         rsp_bus.ready <= 1'b1;
         repeat (($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40)) @(negedge clock);
         gap = idle_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   end

   initial begin
      pixel_mode_type phase_mode [PHASE_COUNT];
      logic           phase_black [PHASE_COUNT];
      int             pause_at;

      reset = 1'b1;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_PIXEL_MODE;
      csr_wr_data = '0;
      req_bus.valid       = 1'b0;
      req_bus.action      = ACT_WRITE;
      req_bus.entry_index = '0;
      req_bus.entry_color = '0;
      req_bus.pixel_byte  = '0;
      req_bus.last_byte   = 1'b0;
      typed_pending = 1'b0;
      typed_lo = '0;
      typed_hi = '0;
      mode_shadow = MODE_8BIT;
      black_clear_shadow = 1'b0;
      foreach (entry_loaded[i]) entry_loaded[i] = 1'b0;

      // mode, black clear, action, index, color, byte, last, typed, argb lo, argb hi
      directed_rows = '{
         '{MODE_8BIT, 1'b0, ACT_WRITE, 8'd0,   16'h0000, 8'hFF, 1'b1, 1'b0, 32'h0, 32'h0},
         '{MODE_8BIT, 1'b0, ACT_WRITE, 8'd255, 16'h7FFF, 8'h00, 1'b0, 1'b0, 32'h0, 32'h0},
         '{MODE_8BIT, 1'b0, ACT_WRITE, 8'd1,   16'h8000, 8'h3C, 1'b1, 1'b0, 32'h0, 32'h0},
         '{MODE_8BIT, 1'b0, ACT_WRITE, 8'd2,   16'hFFFF, 8'hC3, 1'b0, 1'b0, 32'h0, 32'h0},
         '{MODE_8BIT, 1'b0, ACT_WRITE, 8'd3,   16'h001F, 8'h00, 1'b0, 1'b0, 32'h0, 32'h0},
         '{MODE_8BIT, 1'b0, ACT_WRITE, 8'd4,   16'h03E0, 8'h00, 1'b0, 1'b0, 32'h0, 32'h0},
         '{MODE_8BIT, 1'b0, ACT_WRITE, 8'd5,   16'h7C00, 8'h00, 1'b0, 1'b0, 32'h0, 32'h0},
         '{MODE_8BIT, 1'b0, ACT_WRITE, 8'd6,   16'h0001, 8'h00, 1'b0, 1'b0, 32'h0, 32'h0},
         '{MODE_8BIT, 1'b0, ACT_WRITE, 8'd15,  16'h5555, 8'h00, 1'b0, 1'b0, 32'h0, 32'h0},
         '{MODE_8BIT, 1'b0, ACT_WRITE, 8'hA5,  16'hAAAA, 8'h00, 1'b0, 1'b0, 32'h0, 32'h0},
         // after reset settings: opaque black, white, semi black, red, green, blue
         '{MODE_8BIT, 1'b0, ACT_PIXEL, 8'h5A, 16'hFFFF, 8'h00, 1'b0, 1'b1, 32'hFF00_0000, 32'h0},
         '{MODE_8BIT, 1'b0, ACT_PIXEL, 8'hFF, 16'h1234, 8'hFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'h0},
         '{MODE_8BIT, 1'b0, ACT_PIXEL, 8'h00, 16'h0000, 8'h01, 1'b0, 1'b1, 32'h0000_0000, 32'h0},
         '{MODE_8BIT, 1'b0, ACT_PIXEL, 8'hFF, 16'hFFFF, 8'h02, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'h0},
         '{MODE_8BIT, 1'b0, ACT_PIXEL, 8'h11, 16'h0F0F, 8'h03, 1'b0, 1'b1, 32'hFFFF_0000, 32'h0},
         '{MODE_8BIT, 1'b0, ACT_PIXEL, 8'h22, 16'hF0F0, 8'h04, 1'b0, 1'b1, 32'hFF00_FF00, 32'h0},
         '{MODE_8BIT, 1'b0, ACT_PIXEL, 8'h33, 16'h00FF, 8'h05, 1'b0, 1'b1, 32'hFF00_00FF, 32'h0},
         '{MODE_8BIT, 1'b0, ACT_PIXEL, 8'h44, 16'hFF00, 8'h06, 1'b0, 1'b0, 32'h0, 32'h0},
         '{MODE_8BIT, 1'b0, ACT_PIXEL, 8'h55, 16'h8001, 8'hA5, 1'b1, 1'b0, 32'h0, 32'h0},
         // two pixels per byte, low nibble first
         '{MODE_4BIT, 1'b0, ACT_PIXEL, 8'h66, 16'h7777, 8'h10, 1'b1, 1'b1,
           32'hFF00_0000, 32'h0000_0000},
         '{MODE_4BIT, 1'b0, ACT_PIXEL, 8'h77, 16'h8888, 8'h2F, 1'b0, 1'b0, 32'h0, 32'h0},
         // forced black transparency
         '{MODE_8BIT, 1'b1, ACT_PIXEL, 8'h88, 16'h9999, 8'h00, 1'b0, 1'b1, 32'h0000_0000, 32'h0},
         '{MODE_8BIT, 1'b1, ACT_PIXEL, 8'h99, 16'hAAAA, 8'h01, 1'b1, 1'b1, 32'h0000_0000, 32'h0},
         '{MODE_4BIT, 1'b1, ACT_PIXEL, 8'hAA, 16'hBBBB, 8'h01, 1'b1, 1'b1,
           32'h0000_0000, 32'h0000_0000},
         '{MODE_4BIT, 1'b1, ACT_PIXEL, 8'hBB, 16'hCCCC, 8'h6F, 1'b0, 1'b0, 32'h0, 32'h0}
      };

      phase_mode  = '{MODE_8BIT, MODE_4BIT, MODE_4BIT, MODE_8BIT, MODE_8BIT, MODE_8BIT};
      phase_black = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
      for (int p = 4; p < PHASE_COUNT; p++) begin
         phase_mode[p]  = pixel_mode_type'($urandom_range(0, 1));
         phase_black[p] = 1'($urandom_range(0, 1));
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].mode != mode_shadow ||
             directed_rows[r].black_clear != black_clear_shadow) begin
            drain(4);
            write_settings(directed_rows[r].mode, directed_rows[r].black_clear);
         end
         send_txn(directed_rows[r].action, directed_rows[r].entry_index,
                  directed_rows[r].entry_color, directed_rows[r].pixel_byte,
                  directed_rows[r].last_byte, idle_gap(), directed_rows[r].typed,
                  directed_rows[r].argb_lo, directed_rows[r].argb_hi);
      end

      for (int p = 0; p < PHASE_COUNT; p++) begin
         drain(4);
         write_settings(phase_mode[p], phase_black[p]);
         pause_at = $urandom_range(30, PHASE_ITEMS - 10);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n == pause_at) drain(0);
            // opening stretch of each phase runs back to back
            send_random_item(n < 25);
         end
      end

      drain(10);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/clutd_pkg.sv
src/clutd_ifs.sv
src/clutd_palette_ram.sv
src/clutd_color_conv.sv
src/clut_pixel_decoder_top.sv
test/clut_pixel_decoder_top_tb.sv
